@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the grid search block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/bcis_pkg.sv @@
// ----------------------------------------------------------------------------
// bcis_pkg
// Types, constants and helpers shared by the bilinear cell grid search block.
// ----------------------------------------------------------------------------
package bcis_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned CntWidth   = 7;
  localparam int unsigned BaseWidth  = 15;
  localparam int unsigned IdxWidth   = 32;
  localparam int unsigned FracWidth  = 16;
  // weight up to 127*127 (14 bit unsigned)
  localparam int unsigned WgtWidth   = 2 * CntWidth;
  // scaled coordinate: sum of four 16x14 products, plus sign and headroom
  localparam int unsigned PosWidth   = CoordWidth + WgtWidth + 3;
  localparam int unsigned DiffWidth  = PosWidth + 1;
  localparam int unsigned DistWidth  = 62;

  localparam logic [CntWidth-1:0] CntReset = 7'd100;

  typedef enum logic {
    REG_SAMPLES_I = 1'b0,
    REG_SAMPLES_K = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] query_x;
    logic signed [CoordWidth-1:0] query_z;
    logic signed [CoordWidth-1:0] corner00_x;
    logic signed [CoordWidth-1:0] corner00_z;
    logic signed [CoordWidth-1:0] corner10_x;
    logic signed [CoordWidth-1:0] corner10_z;
    logic signed [CoordWidth-1:0] corner01_x;
    logic signed [CoordWidth-1:0] corner01_z;
    logic signed [CoordWidth-1:0] corner11_x;
    logic signed [CoordWidth-1:0] corner11_z;
    logic        [BaseWidth-1:0]  base_i;
    logic        [BaseWidth-1:0]  base_k;
  } in_item_t;

  typedef struct packed {
    logic [CntWidth-1:0] best_sample_i;
    logic [CntWidth-1:0] best_sample_k;
    logic [IdxWidth-1:0] index_i_q16;
    logic [IdxWidth-1:0] index_k_q16;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch item, clear best
    logic sample;    // issue lattice sample (a,b) into the pipe
    logic div_start; // begin fraction division
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy; // samples still in flight
    logic div_done;
  } dp_sts_t;

  function automatic logic [CntWidth-1:0] eff_count(input logic [CntWidth-1:0] r);
    eff_count = (r == '0) ? CntWidth'(1) : r;
  endfunction

endpackage

@@ hw/rtl/bcis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcis_ctrl
// Sequencer: walks the sample lattice and steps the result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcis_ctrl import bcis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [CntWidth-1:0] ni_i,
  input  logic [CntWidth-1:0] nk_i,
  output logic [CntWidth-1:0] a_o,
  output logic [CntWidth-1:0] b_o,
  output dp_cmd_t             cmd_o,
  input  dp_sts_t             sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [CntWidth-1:0] a_q, b_q;
  logic                out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign a_o         = a_q;
  assign b_o         = b_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_valid_i && (state_q == ST_IDLE);
    cmd_o.sample    = (state_q == ST_WALK);
    cmd_o.div_start = (state_q == ST_DRAIN) && !sts_i.pipe_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            a_q     <= '0;
            b_q     <= '0;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (a_q == ni_i) begin
            a_q <= '0;
            if (b_q == nk_i) begin
              state_q <= ST_DRAIN;
            end else begin
              b_q <= b_q + CntWidth'(1);
            end
          end else begin
            a_q <= a_q + CntWidth'(1);
          end
        end
        ST_DRAIN: begin
          if (!sts_i.pipe_busy) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_le_ni, clk_i, rst_ni, (state_q != ST_WALK) || (a_q <= ni_i))
  `ASSERT_CLK(valid_in_out, clk_i, rst_ni, out_valid_q == (state_q == ST_OUT))
  `ASSERT_NEXT(load_walk, clk_i, rst_ni, cmd_o.load, state_q == ST_WALK && a_q == '0 && b_q == '0)

endmodule

@@ hw/rtl/bcis_dp.sv @@
// ----------------------------------------------------------------------------
// bcis_dp
// Datapath: bilinear weights, scaled point, squared distance, best-of search
// and the restoring division for the index fractions.
// ----------------------------------------------------------------------------
module bcis_dp import bcis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            item_i,
  input  logic [CntWidth-1:0] ni_i,
  input  logic [CntWidth-1:0] nk_i,
  input  logic [CntWidth-1:0] a_i,
  input  logic [CntWidth-1:0] b_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output out_item_t           res_o
);

  localparam int unsigned DivBits = FracWidth + CntWidth;
  localparam int unsigned DivCntW = $clog2(DivBits + 1);

  in_item_t item_q;

  // stage 1: weights
  logic                v1_q;
  logic [CntWidth-1:0] a1_q, b1_q;
  logic [WgtWidth-1:0] w00_q, w10_q, w01_q, w11_q;
  logic signed [PosWidth-1:0] qx_q, qz_q;
  // stage 2: products
  logic                v2_q;
  logic [CntWidth-1:0] a2_q, b2_q;
  logic signed [PosWidth-1:0] px0_q, px1_q, px2_q, px3_q;
  logic signed [PosWidth-1:0] pz0_q, pz1_q, pz2_q, pz3_q;
  // stage 3: differences
  logic                v3_q;
  logic [CntWidth-1:0] a3_q, b3_q;
  logic [DiffWidth-1:0] dx_q, dz_q;
  // stage 4: squares
  logic                v4_q;
  logic [CntWidth-1:0] a4_q, b4_q;
  logic [DistWidth-1:0] sx_q, sz_q;

  logic [DistWidth-1:0] best_q;
  logic [CntWidth-1:0]  best_a_q, best_b_q;

  logic [CntWidth-1:0] di_a, di_b;
  logic [CntWidth-1:0] ni_m_a, nk_m_b;
  logic signed [WgtWidth:0] sw00, sw10, sw01, sw11;
  logic signed [PosWidth-1:0] px_sum, pz_sum;
  logic signed [DiffWidth-1:0] ex, ez;
  logic [DistWidth-1:0] dsum;

  // division state
  logic                 div_busy_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic [DivBits-1:0]   numi_q, numk_q, quoi_q, quok_q;
  logic [CntWidth:0]    remi_q, remk_q;
  logic [CntWidth:0]    ri_sh, rk_sh;
  logic [WgtWidth-1:0]  s_full;

  assign ni_m_a = ni_i - a_i;
  assign nk_m_b = nk_i - b_i;
  assign s_full = WgtWidth'(ni_i) * WgtWidth'(nk_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.sample;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign sw00 = signed'({1'b0, w00_q});
  assign sw10 = signed'({1'b0, w10_q});
  assign sw01 = signed'({1'b0, w01_q});
  assign sw11 = signed'({1'b0, w11_q});

  assign px_sum = px0_q + px1_q + px2_q + px3_q;
  assign pz_sum = pz0_q + pz1_q + pz2_q + pz3_q;
  assign ex = DiffWidth'(qx_q) - DiffWidth'(px_sum);
  assign ez = DiffWidth'(qz_q) - DiffWidth'(pz_sum);
  assign dsum = sx_q + sz_q;

  always_ff @(posedge clk_i) begin
    // stage 1
    a1_q  <= a_i;
    b1_q  <= b_i;
    w00_q <= WgtWidth'(ni_m_a) * WgtWidth'(nk_m_b);
    w10_q <= WgtWidth'(a_i) * WgtWidth'(nk_m_b);
    w01_q <= WgtWidth'(ni_m_a) * WgtWidth'(b_i);
    w11_q <= WgtWidth'(a_i) * WgtWidth'(b_i);
    qx_q  <= PosWidth'(item_q.query_x) * signed'({1'b0, s_full});
    qz_q  <= PosWidth'(item_q.query_z) * signed'({1'b0, s_full});
    // stage 2
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    px0_q <= PosWidth'(item_q.corner00_x * sw00);
    px1_q <= PosWidth'(item_q.corner10_x * sw10);
    px2_q <= PosWidth'(item_q.corner01_x * sw01);
    px3_q <= PosWidth'(item_q.corner11_x * sw11);
    pz0_q <= PosWidth'(item_q.corner00_z * sw00);
    pz1_q <= PosWidth'(item_q.corner10_z * sw10);
    pz2_q <= PosWidth'(item_q.corner01_z * sw01);
    pz3_q <= PosWidth'(item_q.corner11_z * sw11);
    // stage 3: magnitudes
    a3_q <= a2_q;
    b3_q <= b2_q;
    dx_q <= ex[DiffWidth-1] ? DiffWidth'(-ex) : DiffWidth'(ex);
    dz_q <= ez[DiffWidth-1] ? DiffWidth'(-ez) : DiffWidth'(ez);
    // stage 4
    a4_q <= a3_q;
    b4_q <= b3_q;
    sx_q <= DistWidth'(dx_q) * DistWidth'(dx_q);
    sz_q <= DistWidth'(dz_q) * DistWidth'(dz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= '1;
      best_a_q <= '0;
      best_b_q <= '0;
    end else if (cmd_i.load) begin
      best_q   <= '1;
      best_a_q <= '0;
      best_b_q <= '0;
    end else if (v4_q && (dsum < best_q)) begin
      best_q   <= dsum;
      best_a_q <= a4_q;
      best_b_q <= b4_q;
    end
  end

  // restoring division, one quotient bit per cycle for both fractions
  assign ri_sh = {remi_q[CntWidth-1:0], numi_q[DivBits-1]};
  assign rk_sh = {remk_q[CntWidth-1:0], numk_q[DivBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DivCntW'(DivBits);
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
      if (div_cnt_q == DivCntW'(1)) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      numi_q <= {best_a_q, FracWidth'(0)};
      numk_q <= {best_b_q, FracWidth'(0)};
      remi_q <= '0;
      remk_q <= '0;
      quoi_q <= '0;
      quok_q <= '0;
    end else if (div_busy_q) begin
      numi_q <= numi_q << 1;
      numk_q <= numk_q << 1;
      if (ri_sh >= {1'b0, ni_i}) begin
        remi_q <= ri_sh - {1'b0, ni_i};
        quoi_q <= {quoi_q[DivBits-2:0], 1'b1};
      end else begin
        remi_q <= ri_sh;
        quoi_q <= {quoi_q[DivBits-2:0], 1'b0};
      end
      if (rk_sh >= {1'b0, nk_i}) begin
        remk_q <= rk_sh - {1'b0, nk_i};
        quok_q <= {quok_q[DivBits-2:0], 1'b1};
      end else begin
        remk_q <= rk_sh;
        quok_q <= {quok_q[DivBits-2:0], 1'b0};
      end
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign sts_o.div_done  = div_busy_q && (div_cnt_q == DivCntW'(1));

  assign res_o.best_sample_i = best_a_q;
  assign res_o.best_sample_k = best_b_q;
  assign res_o.index_i_q16   = {1'b0, item_q.base_i, FracWidth'(0)} + IdxWidth'(quoi_q);
  assign res_o.index_k_q16   = {1'b0, item_q.base_k, FracWidth'(0)} + IdxWidth'(quok_q);

endmodule

@@ hw/rtl/bilinear_cell_inverse_by_sampling_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_cell_inverse_by_sampling_top
// Grid search inverse of a bilinear cell map.
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   in_data_i  (in_item_t)
// out      out  out_valid_o / out_ready_i out_data_o (out_item_t)
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item walks (ni+1)*(nk+1) lattice samples, one lattice sample per cycle
// through a four-stage distance pipe, then a bit-serial index division.
// One item is in work at a time; in_ready_o is high only when idle.
// The result is held until taken. Reset sets both counts to 100.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_cell_inverse_by_sampling_top import bcis_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [CntWidth-1:0] cfg_data_i
);

  logic [CntWidth-1:0] samples_i_q, samples_k_q;
  logic [CntWidth-1:0] ni, nk, a, b;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_i_q <= CntReset;
      samples_k_q <= CntReset;
    end else if (cfg_valid_i && cfg_index_i[1] == 1'b0) begin
      unique case (reg_idx_e'(cfg_index_i[0]))
        REG_SAMPLES_I: samples_i_q <= cfg_data_i;
        REG_SAMPLES_K: samples_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ni = eff_count(samples_i_q);
  assign nk = eff_count(samples_k_q);

  bcis_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .ni_i(ni), .nk_i(nk), .a_o(a), .b_o(b), .cmd_o(cmd), .sts_i(sts)
  );

  bcis_dp u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .ni_i(ni), .nk_i(nk),
    .a_i(a), .b_i(b), .cmd_i(cmd), .sts_o(sts), .res_o(out_data_o)
  );

  `ASSERT_CLK(no_load_busy, clk_i, rst_ni, !(cmd.load && out_valid_o))
  `ASSERT_CLK(no_div_in_walk, clk_i, rst_ni, !(cmd.div_start && cmd.sample))

endmodule
